/* rtl/core/complex_arithmetic_unit_assert.svh */
// Assertion macros shared by the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define CAU_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("complex arithmetic unit check failed");
// Next-cycle implication, checked outside reset.
`define CAU_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("complex arithmetic unit check failed");
`endif

/* rtl/core/cau_pkg.sv */
// Shared types, constants and helper functions for the complex arithmetic unit.
package cau_pkg;
    localparam int WORD_BITS   = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_W      = 2 * WORD_BITS;
    localparam int SUM_W       = PROD_W + 1;
    localparam int QMAG_W      = PROD_W + FRAC_BITS;
    localparam int TR_W        = SUM_W - FRAC_BITS;
    localparam int CNT_W       = $clog2(QMAG_W);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic signed [TR_W-1:0] TR_MAX = TR_W'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam logic signed [TR_W-1:0] TR_MIN = -TR_MAX - TR_W'(1);
    localparam logic [QMAG_W-1:0] Q_MAX = QMAG_W'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic [1:0]                  action;
        logic signed [WORD_BITS-1:0] left_real;
        logic signed [WORD_BITS-1:0] left_imag;
        logic signed [WORD_BITS-1:0] right_real;
        logic signed [WORD_BITS-1:0] right_imag;
    } t_cau_in;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] result_real;
        logic signed [WORD_BITS-1:0] result_imag;
        logic [1:0]                  status;
    } t_cau_out;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] val;
        logic                        sat;
    } t_sat;

    function automatic t_sat sat_word(input logic signed [TR_W-1:0] v);
        t_sat r;
        r.sat = 1'b1;
        if (v > TR_MAX) begin
            r.val = W_MAX;
        end else if (v < TR_MIN) begin
            r.val = W_MIN;
        end else begin
            r.val = v[WORD_BITS-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // Quotient magnitude with its sign; the negative side reaches one step further.
    function automatic t_sat sat_quot(input logic neg, input logic [QMAG_W-1:0] q);
        t_sat r;
        r.sat = 1'b1;
        if (!neg && q > Q_MAX) begin
            r.val = W_MAX;
        end else if (neg && q > Q_MAX + QMAG_W'(1)) begin
            r.val = W_MIN;
        end else begin
            r.val = neg ? -q[WORD_BITS-1:0] : q[WORD_BITS-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction
endpackage

/* rtl/core/cau_front.sv */
// Front end: takes command words and holds them in a short queue for the back end.
module cau_front
    import cau_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cau_in i_item,
    input  logic    i_pop,
    output t_cau_in o_head,
    output logic    o_head_vld
);
    t_cau_in           r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              push, pop;

    assign busy       = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign push       = start && !busy;
    assign o_head_vld = (r_cnt != '0);
    assign pop        = i_pop && o_head_vld;
    assign o_head     = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= r_cnt + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_item;
        end
    end
endmodule

/* rtl/core/cau_div.sv */
// Restoring divider that forms the real and imaginary quotient magnitudes together.
module cau_div
    import cau_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_div_ctl                i_ctl,
    input  logic signed [SUM_W-1:0] i_num_re,
    input  logic signed [SUM_W-1:0] i_num_im,
    input  logic [PROD_W-1:0]       i_den,
    output t_div_stat               o_stat,
    output logic [QMAG_W-1:0]       o_q_re,
    output logic [QMAG_W-1:0]       o_q_im
);
    logic                r_busy, r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [QMAG_W-1:0]   r_nr, r_ni;
    logic [PROD_W-1:0]   r_rr, r_ri, r_den;
    logic [SUM_W-1:0]    abs_re, abs_im;
    logic [PROD_W:0]     sh_re, sh_im;
    logic                ge_re, ge_im;

    assign abs_re = i_num_re[SUM_W-1] ? -i_num_re : i_num_re;
    assign abs_im = i_num_im[SUM_W-1] ? -i_num_im : i_num_im;

    assign sh_re = {r_rr, r_nr[QMAG_W-1]};
    assign sh_im = {r_ri, r_ni[QMAG_W-1]};
    assign ge_re = (sh_re >= {1'b0, r_den});
    assign ge_im = (sh_im >= {1'b0, r_den});

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_q_re      = r_nr;
    assign o_q_im      = r_ni;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Numerator bits leave at the top while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_nr  <= QMAG_W'(abs_re[PROD_W-1:0]) << FRAC_BITS;
            r_ni  <= QMAG_W'(abs_im[PROD_W-1:0]) << FRAC_BITS;
            r_rr  <= '0;
            r_ri  <= '0;
            r_den <= i_den;
            r_cnt <= CNT_W'(QMAG_W - 1);
        end else if (r_busy) begin
            r_nr  <= {r_nr[QMAG_W-2:0], ge_re};
            r_ni  <= {r_ni[QMAG_W-2:0], ge_im};
            r_rr  <= ge_re ? PROD_W'(sh_re - {1'b0, r_den}) : sh_re[PROD_W-1:0];
            r_ri  <= ge_im ? PROD_W'(sh_im - {1'b0, r_den}) : sh_im[PROD_W-1:0];
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end
endmodule

/* rtl/core/cau_back.sv */
// Back end: product stage, sum stage with divider hand-off, and the result register.
module cau_back
    import cau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cau_in   i_head,
    input  logic      i_head_vld,
    output logic      o_pop,
    output logic      o_valid,
    output t_cau_out  o_result,
    output t_div_stat o_div_stat
);
    logic                        r_p_vld, r_s_vld, r_s_started, r_o_vld;
    logic [1:0]                  r_p_op, r_s_op;
    logic signed [WORD_BITS:0]   r_p_lin_re, r_p_lin_im, r_s_lin_re, r_s_lin_im;
    logic signed [PROD_W-1:0]    r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_sq_r, r_p_sq_i;
    logic signed [SUM_W-1:0]     r_s_sum_re, r_s_sum_im;
    logic [PROD_W-1:0]           r_s_den;
    t_cau_out                    r_o;

    logic                        p_adv, s_adv, s_fin, is_sub;
    t_div_ctl                    div_ctl;
    t_div_stat                   div_stat;
    logic [QMAG_W-1:0]           q_re, q_im;
    logic signed [SUM_W-1:0]     adj_re, adj_im;
    t_sat                        f_re, f_im;
    t_cau_out                    fin;

    assign s_fin = r_s_vld && (r_s_op != OP_DIV || r_s_den == '0 || div_stat.done);
    assign s_adv = !r_s_vld || s_fin;
    assign p_adv = !r_p_vld || s_adv;
    assign o_pop = p_adv && i_head_vld;
    assign is_sub = (i_head.action == OP_SUB);

    assign div_ctl.start = r_s_vld && r_s_op == OP_DIV && r_s_den != '0 &&
                           !div_stat.busy && !div_stat.done && !r_s_started;

    cau_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (div_ctl),
        .i_num_re (r_s_sum_re),
        .i_num_im (r_s_sum_im),
        .i_den    (r_s_den),
        .o_stat   (div_stat),
        .o_q_re   (q_re),
        .o_q_im   (q_im)
    );

    // Truncation toward zero: negative sums are biased up before the arithmetic shift.
    assign adj_re = r_s_sum_re + (r_s_sum_re[SUM_W-1] ? SUM_W'((1 << FRAC_BITS) - 1) : '0);
    assign adj_im = r_s_sum_im + (r_s_sum_im[SUM_W-1] ? SUM_W'((1 << FRAC_BITS) - 1) : '0);

    always_comb begin
        case (r_s_op)
            OP_ADD, OP_SUB: begin
                f_re = sat_word(TR_W'(r_s_lin_re));
                f_im = sat_word(TR_W'(r_s_lin_im));
            end
            OP_MUL: begin
                f_re = sat_word($signed(adj_re[SUM_W-1:FRAC_BITS]));
                f_im = sat_word($signed(adj_im[SUM_W-1:FRAC_BITS]));
            end
            default: begin
                f_re = sat_quot(r_s_sum_re[SUM_W-1], q_re);
                f_im = sat_quot(r_s_sum_im[SUM_W-1], q_im);
            end
        endcase
        fin.result_real = f_re.val;
        fin.result_imag = f_im.val;
        fin.status      = (f_re.sat || f_im.sat) ? ST_SAT : ST_OK;
        if (r_s_op == OP_DIV && r_s_den == '0) begin
            fin.result_real = '0;
            fin.result_imag = '0;
            fin.status      = ST_DIV0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld     <= 1'b0;
            r_s_vld     <= 1'b0;
            r_s_started <= 1'b0;
            r_o_vld     <= 1'b0;
        end else begin
            if (p_adv) begin
                r_p_vld <= i_head_vld;
            end
            if (s_adv) begin
                r_s_vld     <= r_p_vld;
                r_s_started <= 1'b0;
            end else if (div_ctl.start) begin
                r_s_started <= 1'b1;
            end
            r_o_vld <= s_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_adv) begin
            r_p_op     <= i_head.action;
            r_p_lin_re <= is_sub ? (WORD_BITS+1)'(i_head.left_real) - i_head.right_real
                                 : (WORD_BITS+1)'(i_head.left_real) + i_head.right_real;
            r_p_lin_im <= is_sub ? (WORD_BITS+1)'(i_head.left_imag) - i_head.right_imag
                                 : (WORD_BITS+1)'(i_head.left_imag) + i_head.right_imag;
            r_p_rr     <= PROD_W'(i_head.left_real) * PROD_W'(i_head.right_real);
            r_p_ii     <= PROD_W'(i_head.left_imag) * PROD_W'(i_head.right_imag);
            r_p_ri     <= PROD_W'(i_head.left_real) * PROD_W'(i_head.right_imag);
            r_p_ir     <= PROD_W'(i_head.left_imag) * PROD_W'(i_head.right_real);
            r_p_sq_r   <= PROD_W'(i_head.right_real) * PROD_W'(i_head.right_real);
            r_p_sq_i   <= PROD_W'(i_head.right_imag) * PROD_W'(i_head.right_imag);
        end
        if (s_adv) begin
            r_s_op     <= r_p_op;
            r_s_lin_re <= r_p_lin_re;
            r_s_lin_im <= r_p_lin_im;
            r_s_sum_re <= (r_p_op == OP_MUL) ? SUM_W'(r_p_rr) - SUM_W'(r_p_ii)
                                             : SUM_W'(r_p_rr) + SUM_W'(r_p_ii);
            r_s_sum_im <= (r_p_op == OP_MUL) ? SUM_W'(r_p_ri) + SUM_W'(r_p_ir)
                                             : SUM_W'(r_p_ir) - SUM_W'(r_p_ri);
            r_s_den    <= PROD_W'(r_p_sq_r) + PROD_W'(r_p_sq_i);
        end
        if (s_fin) begin
            r_o <= fin;
        end
    end

    assign o_valid    = r_o_vld;
    assign o_result   = r_o;
    assign o_div_stat = div_stat;
endmodule

/* rtl/core/complex_arithmetic_unit.sv */
// Complex arithmetic unit top level: command queue in front, arithmetic back end behind.
// Add, subtract and multiply words come out one per cycle while no divide holds the back end.
// A divide holds the back end until its quotients are ready; they come from an
// 80-step one-bit-per-cycle divider.
// A 4-word queue keeps start accepted while the back end works; busy rises only when full.
// Reset is synchronous and active low; it empties the queue, pipeline and divider.
module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_cau_in  i_item,
    output logic     o_valid,
    output t_cau_out o_result
);
`include "complex_arithmetic_unit_assert.svh"

    t_cau_in   head;
    logic      head_vld, pop;
    t_div_stat div_stat;

    cau_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_pop      (pop),
        .o_head     (head),
        .o_head_vld (head_vld)
    );

    cau_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_head_vld (head_vld),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .o_div_stat (div_stat)
    );

    `CAU_NEXT(a_div_holds_output, div_stat.busy, !o_valid)
    `CAU_IMPL(a_div0_zero, o_valid && o_result.status == ST_DIV0, o_result.result_real == '0 && o_result.result_imag == '0)
    `CAU_IMPL(a_status_code, o_valid, o_result.status == ST_OK || o_result.status == ST_SAT || o_result.status == ST_DIV0)
endmodule
